>>> sv/optrd_pkg.sv
`default_nettype none

package optrd_pkg;

    // Line and queue sizing
    localparam int LINE_BUFFER_BYTES_DEF = 128;
    localparam int QUEUE_DEPTH_DEF       = 4;

    // Request operation codes
    localparam logic OP_CHAR    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Awaited reply codes
    localparam logic [1:0] PID_RPM      = 2'd0;
    localparam logic [1:0] PID_SPEED    = 2'd1;
    localparam logic [1:0] PID_THROTTLE = 2'd2;
    localparam logic [1:0] PID_UNUSED   = 2'd3;

    // Characters with a role in the parse
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_UC_C  = 8'h43;
    localparam logic [7:0] CH_UC_D  = 8'h44;

    // Position of the last header character (the header is five characters)
    localparam logic [2:0] HDR_LAST_POS = 3'd4;

    // Reciprocal multipliers: floor(v*640/9) and floor(v*25600/255), v < 256
    localparam int          SCALE_SHIFT  = 16;
    localparam logic [30:0] SPEED_MUL    = 31'd4660338;
    localparam logic [30:0] THROTTLE_MUL = 31'd6579301;

    typedef enum logic [2:0] {
        ST_EMPTY      = 3'd0,
        ST_NO_HEADER  = 3'd1,
        ST_PARSE_FAIL = 3'd2,
        ST_RANGE      = 3'd3,
        ST_OK         = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_WS1    = 3'd1,
        PH_VAL1   = 3'd2,
        PH_WS2    = 3'd3,
        PH_VAL2   = 3'd4,
        PH_DONE   = 3'd5,
        PH_FAIL   = 3'd6
    } phase_t;

    typedef struct packed {
        logic       op;
        logic [7:0] character;
        logic [1:0] expected_pid;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  kind;
        logic [13:0] rpm;
        logic [14:0] speed_q8;
        logic [14:0] throttle_q8;
    } result_t;

    // Line record handed from the parser to the value stage
    typedef struct packed {
        status_t    status;
        logic [1:0] kind;
        logic [7:0] first_value;
        logic [7:0] second_value;
    } line_rec_t;

    // Return {is_hex, nibble}
    function automatic logic [4:0] hex_decode(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    // Header character at a match position for a reply code
    function automatic logic [7:0] hdr_char(logic [1:0] pid, logic [2:0] pos);
        logic [7:0] r;
        unique case (pos)
            3'd0: r = CH_FOUR;
            3'd1: r = CH_ONE;
            3'd2: r = CH_SPACE;
            3'd3: r = (pid == PID_THROTTLE) ? CH_ONE : CH_ZERO;
            3'd4: r = (pid == PID_RPM) ? CH_UC_C :
                      (pid == PID_SPEED) ? CH_UC_D : CH_ONE;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Shift in one hex digit; return {overflow, value}, saturating at 255
    function automatic logic [8:0] accumulate(logic [7:0] cur, logic [3:0] d);
        logic [8:0] r;
        if (cur[7:4] != 4'd0) begin
            r = {1'b1, 8'hFF};
        end
        else begin
            r = {1'b0, cur[3:0], d};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/obd_pid_text_response_decoder.sv
// Scan-tool reply line decoder for mode 01 rpm, speed and throttle replies.
// Request side: a queue input. Drive request and raise push; the request is
// taken at a clock edge where push is high and full is low. op selects a
// received character or a forced line end (timeout).
// Result side: a queue output. While empty is low the oldest result sits on
// result; raise pop to take it at the clock edge.
// One request is taken per cycle while full is low. A request that ends a line
// writes a line record into a small queue at the edge that takes it; the value
// stage (one reciprocal multiply) loads the oldest record into the output
// register when that register is empty or being popped. Carriage returns and
// characters inside a line give none.
// When the receiver stalls, the output register holds, records pile up in
// the line queue, and full rises once it holds QUEUE_DEPTH records; it drops
// right after the edge at which a record moves on to the output register.
// Reset clears the line state, the queue and the output valid flag; the first
// request may follow right after reset is released.
`default_nettype none

module obd_pid_text_response_decoder #(
    parameter int LINE_BUFFER_BYTES = optrd_pkg::LINE_BUFFER_BYTES_DEF,
    parameter int QUEUE_DEPTH       = optrd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire optrd_pkg::request_t  request,
    output logic                      empty,
    input  wire logic                 pop,
    output optrd_pkg::result_t        result
);
    import optrd_pkg::*;

    logic      take;
    logic      rec_push;
    line_rec_t rec_in;
    line_rec_t rec_out;
    logic      rec_pop;
    logic      q_empty;

    assign take = push && !full;

    optrd_front #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .request  (request),
        .rec_push (rec_push),
        .rec      (rec_in)
    );

    optrd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_push),
        .wdata (rec_in),
        .pop   (rec_pop),
        .rdata (rec_out),
        .full  (full),
        .empty (q_empty)
    );

    optrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (!q_empty),
        .rec       (rec_out),
        .rec_pop   (rec_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    a_ok_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == ST_OK) |-> (result.kind != PID_UNUSED))
        else $error("ok result with unused reply code");

    a_rpm_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.rpm != 14'd0) |->
        (result.kind == PID_RPM && result.status == ST_OK))
        else $error("rpm value on a result that is not an ok rpm line");

    a_speed_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.speed_q8 != 15'd0) |->
        (result.kind == PID_SPEED && result.status == ST_OK))
        else $error("speed value on a result that is not an ok speed line");

endmodule

`default_nettype wire

>>> sv/optrd_front.sv
`default_nettype none

module optrd_front #(
    parameter int LINE_BUFFER_BYTES = optrd_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire optrd_pkg::request_t  request,
    output logic                      rec_push,
    output optrd_pkg::line_rec_t      rec
);
    import optrd_pkg::*;

    localparam int CW = $clog2(LINE_BUFFER_BYTES);
    localparam logic [CW-1:0] KEEP_LIMIT = CW'(LINE_BUFFER_BYTES - 1);

    logic [CW-1:0] kept_count_reg, kept_count_next;
    logic [2:0]    header_pos_reg, header_pos_next;
    phase_t        phase_reg, phase_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    second_reg, second_next;
    logic          ovf_reg, ovf_next;

    // Results of feeding the current character
    logic [2:0]    f_pos;
    phase_t        f_phase;
    logic [7:0]    f_first;
    logic [7:0]    f_second;
    logic          f_ovf;
    logic [CW-1:0] kept_inc;

    logic [7:0] c;
    logic [1:0] pid;
    logic [4:0] hex;
    logic [8:0] acc1;
    logic [8:0] acc2;

    // Line state seen by the end-of-line classifier
    logic [CW-1:0] e_count;
    phase_t        e_phase;
    logic          e_ovf;
    logic [7:0]    e_first;
    logic [7:0]    e_second;
    status_t       e_status;
    logic          ok;

    assign c    = request.character;
    assign pid  = request.expected_pid;
    assign hex  = hex_decode(c);
    assign acc1 = accumulate(first_reg, hex[3:0]);
    assign acc2 = accumulate(second_reg, hex[3:0]);
    assign kept_inc = kept_count_reg + 1'b1;

    // Assemble the line record
    assign rec = {e_status, pid, e_first, e_second};

    // Advance the parse by one kept character
    always_comb
    begin
        f_pos    = header_pos_reg;
        f_phase  = phase_reg;
        f_first  = first_reg;
        f_second = second_reg;
        f_ovf    = ovf_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (pid != PID_UNUSED) begin
                    if (header_pos_reg <= HDR_LAST_POS && c == hdr_char(pid, header_pos_reg))
                    begin
                        f_pos = header_pos_reg + 1'b1;
                        if (header_pos_reg == HDR_LAST_POS) begin
                            f_phase = PH_WS1;
                        end
                    end
                    else begin
                        f_pos = (c == CH_FOUR) ? 3'd1 : 3'd0;
                    end
                end
            end
            PH_WS1:
            begin
                if (hex[4]) begin
                    f_first = acc1[7:0];
                    f_ovf   = ovf_reg | acc1[8];
                    f_phase = PH_VAL1;
                end
                else if (!is_blank(c)) begin
                    f_phase = PH_FAIL;
                end
            end
            PH_VAL1:
            begin
                if (hex[4]) begin
                    f_first = acc1[7:0];
                    f_ovf   = ovf_reg | acc1[8];
                end
                else if (pid != PID_RPM) begin
                    f_phase = PH_DONE;
                end
                else begin
                    f_phase = is_blank(c) ? PH_WS2 : PH_FAIL;
                end
            end
            PH_WS2:
            begin
                if (hex[4]) begin
                    f_second = acc2[7:0];
                    f_ovf    = ovf_reg | acc2[8];
                    f_phase  = PH_VAL2;
                end
                else if (!is_blank(c)) begin
                    f_phase = PH_FAIL;
                end
            end
            PH_VAL2:
            begin
                if (hex[4]) begin
                    f_second = acc2[7:0];
                    f_ovf    = ovf_reg | acc2[8];
                end
                else begin
                    f_phase = PH_DONE;
                end
            end
            default:
            begin
                f_phase = phase_reg;
            end
        endcase
    end

    // Decide line end and next state
    always_comb
    begin
        kept_count_next = kept_count_reg;
        header_pos_next = header_pos_reg;
        phase_next      = phase_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        ovf_next        = ovf_reg;
        rec_push        = 1'b0;
        e_count         = kept_count_reg;
        e_phase         = phase_reg;
        e_ovf           = ovf_reg;
        e_first         = first_reg;
        e_second        = second_reg;
        if (take) begin
            if (request.op == OP_TIMEOUT || c == CH_LF) begin
                rec_push = 1'b1;
            end
            else if (c != CH_CR) begin
                e_count  = kept_inc;
                e_phase  = f_phase;
                e_ovf    = f_ovf;
                e_first  = f_first;
                e_second = f_second;
                if (kept_inc >= KEEP_LIMIT) begin
                    rec_push = 1'b1;
                end
                else begin
                    kept_count_next = kept_inc;
                    header_pos_next = f_pos;
                    phase_next      = f_phase;
                    first_next      = f_first;
                    second_next     = f_second;
                    ovf_next        = f_ovf;
                end
            end
        end
        // Clear the line after it is handed off
        if (rec_push) begin
            kept_count_next = '0;
            header_pos_next = 3'd0;
            phase_next      = PH_SEARCH;
            first_next      = 8'd0;
            second_next     = 8'd0;
            ovf_next        = 1'b0;
        end
    end

    // Classify the finished line
    always_comb
    begin
        if (pid == PID_RPM) begin
            ok = (e_phase == PH_VAL2);
        end
        else begin
            ok = (e_phase == PH_VAL1) || (e_phase == PH_WS2) ||
                 (e_phase == PH_VAL2) || (e_phase == PH_DONE);
        end
        if (e_count == '0) begin
            e_status = ST_EMPTY;
        end
        else if (e_phase == PH_SEARCH || pid == PID_UNUSED) begin
            e_status = ST_NO_HEADER;
        end
        else if (!ok) begin
            e_status = ST_PARSE_FAIL;
        end
        else if (e_ovf) begin
            e_status = ST_RANGE;
        end
        else begin
            e_status = ST_OK;
        end
    end

    // Hold line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kept_count_reg <= '0;
            header_pos_reg <= 3'd0;
            phase_reg      <= PH_SEARCH;
            first_reg      <= 8'd0;
            second_reg     <= 8'd0;
            ovf_reg        <= 1'b0;
        end
        else begin
            kept_count_reg <= kept_count_next;
            header_pos_reg <= header_pos_next;
            phase_reg      <= phase_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/optrd_queue.sv
`default_nettype none

module optrd_queue #(
    parameter int DEPTH = optrd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire optrd_pkg::line_rec_t  wdata,
    input  wire logic                  pop,
    output optrd_pkg::line_rec_t       rdata,
    output logic                       full,
    output logic                       empty
);
    import optrd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    line_rec_t     slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the line record
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("line queue count past depth");

    a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("line queue lost a pushed record");

endmodule

`default_nettype wire

>>> sv/optrd_back.sv
`default_nettype none

module optrd_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rec_valid,
    input  wire optrd_pkg::line_rec_t  rec,
    output logic                       rec_pop,
    input  wire logic                  pop,
    output logic                       empty,
    output optrd_pkg::result_t         result
);
    import optrd_pkg::*;

    logic        valid_reg, valid_next;
    result_t     result_reg, result_next;
    logic [30:0] speed_prod;
    logic [30:0] throttle_prod;
    logic        room;

    assign empty  = !valid_reg;
    assign result = result_reg;
    assign room   = !valid_reg || pop;
    assign rec_pop = rec_valid && room;

    // Scale the first value by reciprocal multiplication
    assign speed_prod    = 31'(rec.first_value) * SPEED_MUL;
    assign throttle_prod = 31'(rec.first_value) * THROTTLE_MUL;

    // Build the result for the oldest line record
    always_comb
    begin
        result_next.status      = rec.status;
        result_next.kind        = rec.kind;
        result_next.rpm         = 14'd0;
        result_next.speed_q8    = 15'd0;
        result_next.throttle_q8 = 15'd0;
        if (rec.status == ST_OK) begin
            unique case (rec.kind)
                PID_RPM:      result_next.rpm = {rec.first_value, rec.second_value[7:2]};
                PID_SPEED:    result_next.speed_q8 = speed_prod[SCALE_SHIFT +: 15];
                PID_THROTTLE: result_next.throttle_q8 = throttle_prod[SCALE_SHIFT +: 15];
                default:      result_next.rpm = 14'd0;
            endcase
        end
    end

    // Hold the result until popped
    always_comb
    begin
        valid_next = valid_reg;
        if (rec_pop) begin
            valid_next = 1'b1;
        end
        else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop) begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire
